/* design/ifmt_pkg.sv */
package ifmt_pkg;

  // Field geometry
  localparam int MAX_FIELD   = 40;
  localparam int DIGIT_SLOTS = 22;
  localparam int VALUE_W     = 64;
  localparam int CNT_W       = $clog2(MAX_FIELD + 1);
  localparam int PLACE_W     = $clog2(DIGIT_SLOTS + 1);
  localparam int BIT_W       = $clog2(VALUE_W);
  localparam int CALC_W      = ((CNT_W > PLACE_W) ? CNT_W : PLACE_W) + 2;

  // Flag bit positions
  localparam int FL_LEFT     = 0;
  localparam int FL_PLUS     = 1;
  localparam int FL_SPACE    = 2;
  localparam int FL_ZERO     = 3;
  localparam int FL_UNSIGNED = 4;
  localparam int FL_UPPER    = 5;

  // Base selector codes; any other code means hexadecimal
  localparam logic [1:0] BASE_OCT = 2'd0;
  localparam logic [1:0] BASE_DEC = 2'd1;

  // ASCII characters
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_LOWER_A = 8'h61;

  typedef enum logic [1:0] {
    RADIX_OCT,
    RADIX_DEC,
    RADIX_HEX
  } radix_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SCAN,
    ST_SPAD,
    ST_SIGN,
    ST_ZPAD,
    ST_DIGIT,
    ST_LPAD
  } state_e;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [1:0]                base_select;
    logic [5:0]                min_width;
    logic [5:0]                precision;
    logic [5:0]                format_flags;
  } item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_char;
  } char_t;

  // Controls for the digit shift register
  typedef struct packed {
    logic   load;
    logic   conv;
    logic   shift;
    radix_e radix;
  } dig_ctrl_t;

  // One digit value to its ASCII character
  function automatic logic [7:0] digit_char(logic [3:0] d, logic upper);
    logic [7:0] alpha;
    alpha = upper ? CH_UPPER_A : CH_LOWER_A;
    if (d < 4'd10) begin
      return CH_ZERO + {4'b0000, d};
    end
    return alpha + {4'b0000, d} - 8'd10;
  endfunction

endpackage

/* design/ifmt_digits.sv */
module ifmt_digits (
  input  logic                               clk_i,
  input  ifmt_pkg::dig_ctrl_t                ctrl_i,
  input  logic [ifmt_pkg::VALUE_W-1:0]       mag_i,
  output logic [3:0]                         top_digit_o,
  output logic                               top_zero_o
);
  import ifmt_pkg::*;

  logic [VALUE_W-1:0] mag_q;
  logic [3:0]         slot_q [DIGIT_SLOTS];
  logic [3:0]         slot_conv [DIGIT_SLOTS];
  logic [2:0]         keep [DIGIT_SLOTS];
  logic               cout [DIGIT_SLOTS];
  logic [3:0]         adj [DIGIT_SLOTS];

  // Per-slot step: each slot takes one bit from below and passes its top bit up.
  // Decimal slots add three at five or more (shift-and-add-3 conversion).
  always_comb begin
    for (int k = 0; k < DIGIT_SLOTS; k++) begin
      adj[k] = (slot_q[k] >= 4'd5) ? slot_q[k] + 4'd3 : slot_q[k];
      case (ctrl_i.radix)
        RADIX_OCT: begin
          cout[k] = slot_q[k][2];
          keep[k] = {1'b0, slot_q[k][1:0]};
        end
        RADIX_DEC: begin
          cout[k] = adj[k][3];
          keep[k] = adj[k][2:0];
        end
        default: begin
          cout[k] = slot_q[k][3];
          keep[k] = slot_q[k][2:0];
        end
      endcase
    end
    // Bottom slot takes the next magnitude bit, the others the carry from below
    slot_conv[0] = {keep[0], mag_q[VALUE_W-1]};
    for (int k = 1; k < DIGIT_SLOTS; k++) begin
      slot_conv[k] = {keep[k], cout[k-1]};
    end
  end

  // Magnitude shifts out MSB first; digits shift up one slot on output
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      mag_q <= mag_i;
      for (int k = 0; k < DIGIT_SLOTS; k++) slot_q[k] <= 4'd0;
    end else if (ctrl_i.conv) begin
      mag_q <= {mag_q[VALUE_W-2:0], 1'b0};
      for (int k = 0; k < DIGIT_SLOTS; k++) slot_q[k] <= slot_conv[k];
    end else if (ctrl_i.shift) begin
      for (int k = DIGIT_SLOTS - 1; k > 0; k--) slot_q[k] <= slot_q[k-1];
      slot_q[0] <= 4'd0;
    end
  end

  assign top_digit_o = slot_q[DIGIT_SLOTS-1];
  assign top_zero_o  = (slot_q[DIGIT_SLOTS-1] == 4'd0);

endmodule

/* design/ifmt_seq.sv */
module ifmt_seq (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  ifmt_pkg::item_t              in_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output ifmt_pkg::char_t              out_o,
  output ifmt_pkg::dig_ctrl_t          dig_ctrl_o,
  output logic [ifmt_pkg::VALUE_W-1:0] mag_o,
  input  logic [3:0]                   top_digit_i,
  input  logic                         top_zero_i
);
  import ifmt_pkg::*;

  state_e             state_q, state_d;
  radix_e             radix_q, radix_d;
  logic [BIT_W-1:0]   bit_q, bit_d;
  logic [PLACE_W-1:0] place_q, place_d;
  logic [CNT_W-1:0]   width_q, width_d;
  logic [CNT_W-1:0]   prec_q, prec_d;
  logic [CNT_W-1:0]   spad_q, spad_d;
  logic [CNT_W-1:0]   zpad_q, zpad_d;
  logic [CNT_W-1:0]   lpad_q, lpad_d;
  logic [5:0]         flags_q, flags_d;
  logic               has_sign_q, has_sign_d;
  logic [7:0]         sign_ch_q, sign_ch_d;
  logic               out_valid_q, out_valid_d;
  char_t              out_q, out_d;

  logic               accept;
  logic               slot_free;
  logic               negative;
  logic [CALC_W-1:0]  c_place, c_prec, c_width, c_wide, c_used, c_zp, c_sp;

  assign accept    = in_valid_i && (state_q == ST_IDLE);
  assign slot_free = !out_valid_q || !out_stall_i;
  assign negative  = !in_i.format_flags[FL_UNSIGNED] && in_i.value[VALUE_W-1];
  assign mag_o     = negative ? (VALUE_W'(0) - $unsigned(in_i.value)) : $unsigned(in_i.value);

  // Pad lengths from the significant digit count
  always_comb begin
    c_place = CALC_W'(place_q);
    c_prec  = CALC_W'(prec_q);
    c_width = CALC_W'(width_q);
    c_zp    = (c_prec > c_place) ? c_prec - c_place : '0;
    c_wide  = (c_prec > c_place) ? c_prec : c_place;
    c_used  = c_wide + CALC_W'(has_sign_q);
    c_sp    = (c_width > c_used) ? c_width - c_used : '0;
  end

  // Next state and outputs
  always_comb begin
    state_d     = state_q;
    radix_d     = radix_q;
    bit_d       = bit_q;
    place_d     = place_q;
    width_d     = width_q;
    prec_d      = prec_q;
    spad_d      = spad_q;
    zpad_d      = zpad_q;
    lpad_d      = lpad_q;
    flags_d     = flags_q;
    has_sign_d  = has_sign_q;
    sign_ch_d   = sign_ch_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    dig_ctrl_o  = '{load: 1'b0, conv: 1'b0, shift: 1'b0, radix: radix_q};

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          dig_ctrl_o.load = 1'b1;
          case (in_i.base_select)
            BASE_OCT: radix_d = RADIX_OCT;
            BASE_DEC: radix_d = RADIX_DEC;
            default:  radix_d = RADIX_HEX;
          endcase
          width_d = ({1'b0, in_i.min_width} > 7'(MAX_FIELD)) ?
                    CNT_W'(MAX_FIELD) : in_i.min_width[CNT_W-1:0];
          prec_d  = ({1'b0, in_i.precision} > 7'(MAX_FIELD)) ?
                    CNT_W'(MAX_FIELD) : in_i.precision[CNT_W-1:0];
          flags_d = in_i.format_flags;
          bit_d   = '0;
          if (in_i.format_flags[FL_UNSIGNED]) begin
            has_sign_d = 1'b0;
            sign_ch_d  = CH_SPACE;
          end else if (negative) begin
            has_sign_d = 1'b1;
            sign_ch_d  = CH_MINUS;
          end else if (in_i.format_flags[FL_PLUS]) begin
            has_sign_d = 1'b1;
            sign_ch_d  = CH_PLUS;
          end else begin
            has_sign_d = in_i.format_flags[FL_SPACE];
            sign_ch_d  = CH_SPACE;
          end
          state_d = ST_CONV;
        end
      end

      // One magnitude bit per cycle into the digit register
      ST_CONV: begin
        dig_ctrl_o.conv = 1'b1;
        bit_d = bit_q + BIT_W'(1);
        if (bit_q == BIT_W'(VALUE_W - 1)) begin
          place_d = PLACE_W'(DIGIT_SLOTS);
          state_d = ST_SCAN;
        end
      end

      // Drop leading zero digits, keeping at least one
      ST_SCAN: begin
        if (top_zero_i && (place_q > PLACE_W'(1))) begin
          dig_ctrl_o.shift = 1'b1;
          place_d = place_q - PLACE_W'(1);
        end else begin
          zpad_d = CNT_W'(c_zp);
          spad_d = CNT_W'(c_sp);
          lpad_d = '0;
          if (flags_q[FL_LEFT]) begin
            lpad_d = CNT_W'(c_sp);
            spad_d = '0;
          end else if (flags_q[FL_ZERO]) begin
            zpad_d = (c_sp > c_zp) ? CNT_W'(c_sp) : CNT_W'(c_zp);
            spad_d = '0;
          end
          state_d = ST_SPAD;
        end
      end

      ST_SPAD: begin
        if (spad_q == '0) begin
          state_d = ST_SIGN;
        end else if (slot_free) begin
          out_valid_d = 1'b1;
          out_d       = '{out_char: CH_SPACE, last_char: 1'b0};
          spad_d      = spad_q - CNT_W'(1);
        end
      end

      ST_SIGN: begin
        if (!has_sign_q) begin
          state_d = ST_ZPAD;
        end else if (slot_free) begin
          out_valid_d = 1'b1;
          out_d       = '{out_char: sign_ch_q, last_char: 1'b0};
          state_d     = ST_ZPAD;
        end
      end

      ST_ZPAD: begin
        if (zpad_q == '0) begin
          state_d = ST_DIGIT;
        end else if (slot_free) begin
          out_valid_d = 1'b1;
          out_d       = '{out_char: CH_ZERO, last_char: 1'b0};
          zpad_d      = zpad_q - CNT_W'(1);
        end
      end

      // Most significant digit sits in the top slot
      ST_DIGIT: begin
        if (slot_free) begin
          out_valid_d      = 1'b1;
          out_d.out_char   = digit_char(top_digit_i, flags_q[FL_UPPER]);
          out_d.last_char  = (place_q == PLACE_W'(1)) && (lpad_q == '0);
          dig_ctrl_o.shift = 1'b1;
          place_d          = place_q - PLACE_W'(1);
          if (place_q == PLACE_W'(1)) begin
            state_d = (lpad_q == '0) ? ST_IDLE : ST_LPAD;
          end
        end
      end

      ST_LPAD: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_d       = '{out_char: CH_SPACE, last_char: (lpad_q == CNT_W'(1))};
          lpad_d      = lpad_q - CNT_W'(1);
          if (lpad_q == CNT_W'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Item context and output register
  always_ff @(posedge clk_i) begin
    radix_q    <= radix_d;
    bit_q      <= bit_d;
    place_q    <= place_d;
    width_q    <= width_d;
    prec_q     <= prec_d;
    spad_q     <= spad_d;
    zpad_q     <= zpad_d;
    lpad_q     <= lpad_d;
    flags_q    <= flags_d;
    has_sign_q <= has_sign_d;
    sign_ch_q  <= sign_ch_d;
    out_q      <= out_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

/* design/integer_field_formatter.sv */
// printf-style integer formatter. Each transaction carries a 64-bit value, a radix
// (octal, decimal, hex), a minimum width and precision (both saturating at 40) and
// flags; the block returns the formatted field one ASCII character per output
// transaction, with last_char set on the final one. Conversion is bit-serial: the
// magnitude is shifted MSB first into a 22-slot digit register (shift-and-add-3 for
// decimal), then leading zero digits are stripped, keeping at least one, and the
// pad counts are settled. The characters then leave in order: space padding, sign,
// zero padding, digits and, for a left-justified field, trailing space padding. The
// next item is accepted once the last character of the previous one sits in the
// output register.
module integer_field_formatter (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ifmt_pkg::item_t   in_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ifmt_pkg::char_t   out_o
);
  import ifmt_pkg::*;

  dig_ctrl_t          dig_ctrl;
  logic [VALUE_W-1:0] mag;
  logic [3:0]         top_digit;
  logic               top_zero;

  // Sequencer: sign, padding counts, character output
  ifmt_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o),
    .dig_ctrl_o  (dig_ctrl),
    .mag_o       (mag),
    .top_digit_i (top_digit),
    .top_zero_i  (top_zero)
  );

  // Bit-serial radix conversion and digit shift register
  ifmt_digits u_digits (
    .clk_i       (clk_i),
    .ctrl_i      (dig_ctrl),
    .mag_i       (mag),
    .top_digit_o (top_digit),
    .top_zero_o  (top_zero)
  );

endmodule
